// ===== src/plm_pkg.sv =====
// Package: word types, op codes, sizes and state enums for the per-label mean engine.
`default_nettype none
package plm_pkg;
    localparam int NumLabels  = 256;
    localparam int LabelBits  = 8;
    localparam int SampleBits = 16;
    localparam int CountBits  = 24;
    localparam int CntW       = CountBits + 1;
    localparam int SumW       = 40;
    localparam int EntryW     = SumW + CntW;
    localparam int QDepth     = 4;
    localparam int QPtrW      = 2;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]                   op;
        logic [LabelBits-1:0]         label;
        logic signed [SampleBits-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] mean;
        logic [CntW-1:0]    voxel_count;
        logic               empty_res;
    } out_word_t;

    // command handed from front to back
    typedef struct packed {
        op_t                          op;
        logic [LabelBits-1:0]         label;
        logic signed [SampleBits-1:0] sample;
    } cmd_t;

    typedef enum logic [2:0] {
        B_INIT, B_IDLE, B_READ, B_WRITE, B_DIV, B_OUT
    } back_state_t;
endpackage
`default_nettype wire

// ===== src/per_label_mean_engine.sv =====
// Top level: per-label running mean engine, front queue feeding the table/divide back end.
// Accumulate: a table read, then a modify-write of the entry, in the back end.
// Query: a table read, then the 40-step bit-serial divider, then the result register.
// Clear: sweep over all 256 table entries, one entry per cycle.
// Reset: async active low; a sweep over all 256 table entries follows, words queue meanwhile.
// A 4-word command queue lets input words be taken while the back end is busy.
`default_nettype none
module per_label_mean_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire plm_pkg::in_word_t  in_word,
    output logic                    empty,
    input  wire logic               pop,
    output plm_pkg::out_word_t      out_word
);
    import plm_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    plm_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    plm_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_word(out_word)
    );

    // an empty result always carries zero count and zero mean
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.empty_res) |-> (out_word.voxel_count == '0
        && out_word.mean == '0))
        else $error("empty result with nonzero fields");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_word)))
        else $error("result changed before pop");

    // a nonempty result never reports zero count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_word.empty_res) |-> (out_word.voxel_count != '0))
        else $error("nonempty result with zero count");
endmodule
`default_nettype wire

// ===== src/plm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module plm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/plm_front.sv =====
// Front end: accepts input words, drops no-op codes, queues commands for the back end.
`default_nettype none
module plm_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire plm_pkg::in_word_t in_word,
    output logic                 cmd_valid,
    output plm_pkg::cmd_t        cmd,
    input  wire logic            cmd_take
);
    import plm_pkg::*;

    cmd_t               q_reg [QDepth];
    logic [QPtrW-1:0]   wp_reg, rp_reg;
    logic [QPtrW:0]     cnt_reg, cnt_next;
    logic               wr;

    assign full      = (cnt_reg == QDepth[QPtrW:0]);
    assign wr        = push && !full && (in_word.op != OP_NONE);
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !(cmd_take && cmd_valid))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr && cmd_take && cmd_valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= '{op: op_t'(in_word.op), label: in_word.label,
                               sample: in_word.sample};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (cmd_take && cmd_valid)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/plm_div.sv =====
// Sequential restoring divider: signed 40-bit sum by 25-bit count, truncated quotient.
`default_nettype none
module plm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [plm_pkg::SumW-1:0] dividend,
    input  wire logic [plm_pkg::CntW-1:0]   divisor,
    output logic                            done,
    output logic signed [15:0]              quotient
);
    import plm_pkg::*;

    localparam int StepW = $clog2(SumW + 1);

    logic [SumW-1:0]  q_reg;
    logic [CntW:0]    r_reg;
    logic [CntW-1:0]  d_reg;
    logic             neg_reg, busy_reg;
    logic [StepW-1:0] step_reg;
    logic [CntW:0]    trial;
    logic [SumW-1:0]  mag;
    logic [SumW-1:0]  qs;

    assign mag   = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {r_reg[CntW-1:0], q_reg[SumW-1]};
    assign qs    = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = qs[15:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            r_reg   <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[SumW-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[SumW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == StepW'(SumW - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/plm_back.sv =====
// Back end: table clear sweep, read-modify-write accumulate, query with divide, result register.
`default_nettype none
module plm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire plm_pkg::cmd_t     cmd,
    output logic                   cmd_take,
    output logic                   empty,
    input  wire logic              pop,
    output plm_pkg::out_word_t     out_word
);
    import plm_pkg::*;

    back_state_t          state_reg, state_next;
    logic [LabelBits-1:0] addr_reg, addr_next;
    cmd_t                 cur_reg, cur_next;
    logic                 full_reg, full_next;
    out_word_t            res_reg, res_next;
    out_word_t            out_reg;
    logic                 we;
    logic [LabelBits-1:0] waddr, raddr;
    logic [EntryW-1:0]    wdata, rdata;
    logic signed [SumW-1:0] rsum;
    logic [CntW-1:0]      rcnt;
    logic                 div_start, div_done;
    logic signed [15:0]   div_q;

    assign rsum = rdata[EntryW-1:CntW];
    assign rcnt = rdata[CntW-1:0];
    assign empty    = !full_reg;
    // the word being built lives in res_reg; the word on the ports in out_reg
    assign out_word = out_reg;

    plm_ram #(.Width(EntryW), .Depth(NumLabels)) u_tab (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    plm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rsum),
        .divisor(rcnt), .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cur_next   = cur_reg;
        full_next  = full_reg && !pop;
        res_next   = res_reg;
        cmd_take   = 1'b0;
        we         = 1'b0;
        waddr      = addr_reg;
        wdata      = '0;
        raddr      = cmd.label;
        div_start  = 1'b0;
        unique case (state_reg)
            B_INIT:
            begin
                we        = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LabelBits'(NumLabels - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    cur_next = cmd;
                    unique case (cmd.op)
                        OP_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = B_INIT;
                        end
                        OP_ACCUM, OP_QUERY:
                        begin
                            state_next = B_READ;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                if (cur_reg.op == OP_ACCUM)
                begin
                    state_next = B_WRITE;
                end
                else if (rcnt == '0)
                begin
                    res_next   = '{mean: '0, voxel_count: '0, empty_res: 1'b1};
                    state_next = B_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    res_next   = '{mean: '0, voxel_count: rcnt, empty_res: 1'b0};
                    state_next = B_DIV;
                end
            end
            B_WRITE:
            begin
                waddr = cur_reg.label;
                wdata = {rsum + SumW'(cur_reg.sample), rcnt + 1'b1};
                we    = (rcnt < CntW'(1) << CountBits);
                state_next = B_IDLE;
            end
            B_DIV:
            begin
                raddr = cur_reg.label;
                if (div_done)
                begin
                    res_next.mean = div_q;
                    state_next    = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!full_reg || pop)
                begin
                    full_next  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (state_reg == B_READ)
        begin
            raddr = cur_reg.label;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (state_reg != B_OUT)
        begin
            res_reg <= res_next;
        end
        if (state_reg == B_OUT && (!full_reg || pop))
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_INIT;
            addr_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            full_reg  <= full_next;
        end
    end
endmodule
`default_nettype wire
